// ===== design/vna_pkg.sv =====
package vna_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;

  localparam int unsigned POS_W   = 16;  // Q7.8 coordinate
  localparam int unsigned EDGE_W  = 17;  // difference of two coordinates
  localparam int unsigned CROSS_W = 35;  // cross component, units of 2^-16
  localparam int unsigned MAG_W   = 34;  // magnitude of a cross component
  localparam int unsigned SMAG_W  = 31;  // magnitude after the common shift
  localparam int unsigned SUM_W   = 64;  // sum of three squares
  localparam int unsigned ROOT_W  = 32;  // integer square root of the sum
  localparam int unsigned Q_W     = 15;  // unit component, up to 16384
  localparam int unsigned NRM_W   = 24;  // accumulator word
  localparam int unsigned ONE_SH  = 14;  // one in Q1.14

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic signed [NRM_W:0] ACC_MAX = 25'sd8388607;
  localparam logic signed [NRM_W:0] ACC_MIN = -25'sd8388608;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_LOAD,
    S_RD0,
    S_RD1,
    S_V0,
    S_V1,
    S_V2,
    S_V3,
    S_CROSS,
    S_MAG,
    S_SHIFT,
    S_SQ,
    S_NSTART,
    S_NORM,
    S_ARD,
    S_AWR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    N_IDLE,
    N_SQRT,
    N_DINIT,
    N_DIV
  } norm_state_t;

endpackage

// ===== design/vna_norm.sv =====
module vna_norm import vna_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SMAG_W-1:0] mag [3],
  input  logic [SUM_W-1:0]  sum,
  output logic              done,
  output logic [Q_W-1:0]    quot [3]
);

  norm_state_t nstate, nstate_next;

  logic [SUM_W-1:0]  v;
  logic [ROOT_W+2:0] rem;
  logic [ROOT_W-1:0] root;
  logic [4:0]        cnt;
  logic [1:0]        k;
  logic [ROOT_W-1:0] drem;
  logic [Q_W-1:0]    low;
  logic [Q_W-1:0]    q;

  logic              sqrt_en, div_init, div_en;
  logic [ROOT_W+2:0] rem_sh, trial;
  logic              sq_ge;
  logic [SMAG_W+ONE_SH:0] num;
  logic [ROOT_W:0]   r2;
  logic              dv_ge;

  always_comb begin
    nstate_next = nstate;
    unique case (nstate)
      N_IDLE:  if (start) nstate_next = N_SQRT;
      N_SQRT:  if (cnt == 5'd0) nstate_next = N_DINIT;
      N_DINIT: nstate_next = N_DIV;
      N_DIV:   if (cnt == 5'd0) nstate_next = (k == 2'd2) ? N_IDLE : N_DINIT;
      default: nstate_next = N_IDLE;
    endcase
  end

  always_comb begin
    sqrt_en  = (nstate == N_SQRT);
    div_init = (nstate == N_DINIT);
    div_en   = (nstate == N_DIV);
  end

  // one root digit per cycle
  always_comb begin
    rem_sh = {rem[ROOT_W:0], v[SUM_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    sq_ge  = (rem_sh >= trial);
  end

  // one quotient bit per cycle, rounding half of the root in front
  always_comb begin
    num   = (SMAG_W+ONE_SH+1)'({mag[k], {ONE_SH{1'b0}}}) + (SMAG_W+ONE_SH+1)'(root[ROOT_W-1:1]);
    r2    = {drem, low[Q_W-1]};
    dv_ge = (r2 >= {1'b0, root});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nstate <= N_IDLE;
      done   <= 1'b0;
    end else begin
      nstate <= nstate_next;
      done   <= div_en && (cnt == 5'd0) && (k == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (nstate == N_IDLE && start) begin
      v    <= sum;
      rem  <= '0;
      root <= '0;
      cnt  <= 5'd31;
      k    <= 2'd0;
    end
    if (sqrt_en) begin
      v    <= {v[SUM_W-3:0], 2'b00};
      rem  <= sq_ge ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], sq_ge};
      cnt  <= cnt - 5'd1;
    end
    if (div_init) begin
      drem <= ROOT_W'(num[SMAG_W+ONE_SH:Q_W]);
      low  <= num[Q_W-1:0];
      q    <= '0;
      cnt  <= 5'(Q_W - 1);
    end
    if (div_en) begin
      drem <= dv_ge ? ROOT_W'(r2 - {1'b0, root}) : r2[ROOT_W-1:0];
      low  <= {low[Q_W-2:0], 1'b0};
      q    <= {q[Q_W-2:0], dv_ge};
      cnt  <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        quot[k] <= {q[Q_W-2:0], dv_ge};
        k       <= k + 2'd1;
      end
    end
  end

endmodule

// ===== design/vertex_normal_accumulator.sv =====
// steps from the accepting edge to out_valid: load writes the vertex store, read fetches a normal,
// clear zeroes the normal store; triangle: vertex reads, cross product steps and squares on the
// shared multiplier, magnitude and shift, vna_norm (start, root digits, quotient steps and done),
// the three normal updates, then the output register; a degenerate triangle ends after the shift
// throughput: one word at a time; the next is taken once the result sits in the output register
// reset: synchronous, active high; then the clear state zeroes the normal store, in_ready low
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic [7:0]               index_a,
  input  logic [7:0]               index_b,
  input  logic [7:0]               index_c,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NRM_W-1:0]  normal_x,
  output logic signed [NRM_W-1:0]  normal_y,
  output logic signed [NRM_W-1:0]  normal_z,
  output logic                     degenerate,
  output logic                     saturated
);

  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);

  state_t state, state_next;

  // index reduction table, indices wrap at the store size
  logic [IDX_W-1:0] mod_tbl [256];
  for (genvar i = 0; i < 256; i++) begin : g_mod
    localparam int unsigned MV = i % MAX_VERTICES;
    assign mod_tbl[i] = IDX_W'(MV);
  end

  // captured word
  logic [1:0]       op_q;
  logic [IDX_W-1:0] ia_q, ib_q, ic_q;
  logic [3*POS_W-1:0] pos_q;
  logic             clr_op;
  logic [IDX_W-1:0] clr_cnt;
  logic [2:0]       cnt;

  // geometry datapath
  logic [3*POS_W-1:0]       v0;
  logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [CROSS_W-1:0] c0, c1, c2;
  logic [MAG_W-1:0]  m0, m1, m2;
  logic [SMAG_W-1:0] sm [3];
  logic [SUM_W-1:0]  sum;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;
  logic [MAG_W-1:0]  mag_or;
  logic [1:0]        sh;

  logic           norm_start, norm_done;
  logic [Q_W-1:0] quot [3];

  // result being built
  logic signed [NRM_W-1:0] r_x, r_y, r_z;
  logic r_deg, r_sat;

  // stores
  logic [3*POS_W-1:0] vtx_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] vtx_rd_q;
  logic [IDX_W-1:0]   vtx_rd_addr;
  logic               vtx_we;
  logic [3*NRM_W-1:0] nrm_mem [MAX_VERTICES];
  logic [3*NRM_W-1:0] nrm_rd_q;
  logic [IDX_W-1:0]   nrm_rd_addr, nrm_wr_addr;
  logic               nrm_we;
  logic [3*NRM_W-1:0] nrm_wdata;

  logic [IDX_W-1:0] corner;
  logic [NRM_W:0]   acc_x, acc_y, acc_z;
  logic             in_acc, out_load;

  function automatic logic [NRM_W:0] sat_add(input logic signed [NRM_W-1:0] acc,
                                             input logic signed [NRM_W-1:0] add);
    logic signed [NRM_W:0] s;
    s = (NRM_W+1)'(acc) + (NRM_W+1)'(add);
    if (s > ACC_MAX)      return {1'b1, ACC_MAX[NRM_W-1:0]};
    else if (s < ACC_MIN) return {1'b1, ACC_MIN[NRM_W-1:0]};
    else                  return {1'b0, s[NRM_W-1:0]};
  endfunction

  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:    if (clr_cnt == IDX_W'(MAX_VERTICES - 1))
                  state_next = clr_op ? S_DONE : S_IDLE;
      S_IDLE:   if (in_valid) begin
                  unique case (opcode)
                    OP_LOAD:  state_next = S_LOAD;
                    OP_TRI:   state_next = S_V0;
                    OP_READ:  state_next = S_RD0;
                    OP_CLEAR: state_next = S_CLR;
                    default:  state_next = S_IDLE;
                  endcase
                end
      S_LOAD:   state_next = S_DONE;
      S_RD0:    state_next = S_RD1;
      S_RD1:    state_next = S_DONE;
      S_V0:     state_next = S_V1;
      S_V1:     state_next = S_V2;
      S_V2:     state_next = S_V3;
      S_V3:     state_next = S_CROSS;
      S_CROSS:  if (cnt == 3'd6) state_next = S_MAG;
      S_MAG:    state_next = S_SHIFT;
      S_SHIFT:  state_next = (mag_or == '0) ? S_DONE : S_SQ;
      S_SQ:     if (cnt == 3'd3) state_next = S_NSTART;
      S_NSTART: state_next = S_NORM;
      S_NORM:   if (norm_done) state_next = S_ARD;
      S_ARD:    state_next = S_AWR;
      S_AWR:    if (cnt == 3'd2) state_next = S_DONE; else state_next = S_ARD;
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready    = (state == S_IDLE);
    vtx_we      = (state == S_LOAD);
    norm_start  = (state == S_NSTART);
    nrm_we      = (state == S_CLR) || (state == S_AWR);
    vtx_rd_addr = ia_q;
    nrm_rd_addr = ia_q;
    nrm_wr_addr = clr_cnt;
    nrm_wdata   = '0;
    mul_a       = '0;
    mul_b       = '0;

    unique case (cnt)
      3'd1:    corner = ib_q;
      3'd2:    corner = ic_q;
      default: corner = ia_q;
    endcase

    unique case (state)
      S_V1: vtx_rd_addr = ib_q;
      S_V2: vtx_rd_addr = ic_q;
      default: ;
    endcase

    if (state == S_ARD) nrm_rd_addr = corner;

    // saturating update of one corner, all three components at once
    acc_x = sat_add(nrm_rd_q[3*NRM_W-1 -: NRM_W], r_x);
    acc_y = sat_add(nrm_rd_q[2*NRM_W-1 -: NRM_W], r_y);
    acc_z = sat_add(nrm_rd_q[NRM_W-1 -: NRM_W], r_z);
    if (state == S_AWR) begin
      nrm_wr_addr = corner;
      nrm_wdata   = {acc_x[NRM_W-1:0], acc_y[NRM_W-1:0], acc_z[NRM_W-1:0]};
    end

    // shared multiplier: six cross terms, then three squares
    if (state == S_CROSS) begin
      unique case (cnt)
        3'd0:    begin mul_a = 32'(e1y); mul_b = 32'(e2z); end
        3'd1:    begin mul_a = 32'(e1z); mul_b = 32'(e2y); end
        3'd2:    begin mul_a = 32'(e1z); mul_b = 32'(e2x); end
        3'd3:    begin mul_a = 32'(e1x); mul_b = 32'(e2z); end
        3'd4:    begin mul_a = 32'(e1x); mul_b = 32'(e2y); end
        3'd5:    begin mul_a = 32'(e1y); mul_b = 32'(e2x); end
        default: ;
      endcase
    end else if (state == S_SQ && cnt != 3'd3) begin
      mul_a = {1'b0, sm[cnt[1:0]]};
      mul_b = {1'b0, sm[cnt[1:0]]};
    end

    // smallest common shift that brings the largest magnitude below 2^31
    mag_or = m0 | m1 | m2;
    priority if (mag_or[33]) sh = 2'd3;
    else if (mag_or[32])     sh = 2'd2;
    else if (mag_or[31])     sh = 2'd1;
    else                     sh = 2'd0;
  end

  // ---------------- stores ----------------
  always_ff @(posedge clk) begin
    if (vtx_we) vtx_mem[ia_q] <= pos_q;
    vtx_rd_q <= vtx_mem[vtx_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) nrm_mem[nrm_wr_addr] <= nrm_wdata;
    nrm_rd_q <= nrm_mem[nrm_rd_addr];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_op    <= 1'b0;
      clr_cnt   <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        clr_op  <= 1'b1;
        clr_cnt <= '0;
        cnt     <= '0;
      end
      if (state == S_CLR) clr_cnt <= clr_cnt + IDX_W'(1);
      if (state == S_CROSS || state == S_SQ) cnt <= cnt + 3'd1;
      if (state == S_V3 || state == S_SHIFT || state == S_NORM) cnt <= '0;
      if (state == S_AWR) cnt <= cnt + 3'd1;
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;

    if (in_acc) begin
      op_q  <= opcode;
      ia_q  <= mod_tbl[index_a];
      ib_q  <= mod_tbl[index_b];
      ic_q  <= mod_tbl[index_c];
      pos_q <= {pos_x, pos_y, pos_z};
      r_x   <= '0;
      r_y   <= '0;
      r_z   <= '0;
      r_deg <= 1'b0;
      r_sat <= 1'b0;
    end

    unique case (state)
      S_RD1: begin
        r_x <= nrm_rd_q[3*NRM_W-1 -: NRM_W];
        r_y <= nrm_rd_q[2*NRM_W-1 -: NRM_W];
        r_z <= nrm_rd_q[NRM_W-1 -: NRM_W];
      end
      S_V1: v0 <= vtx_rd_q;
      S_V2: begin
        e1x <= EDGE_W'(signed'(vtx_rd_q[47:32])) - EDGE_W'(signed'(v0[47:32]));
        e1y <= EDGE_W'(signed'(vtx_rd_q[31:16])) - EDGE_W'(signed'(v0[31:16]));
        e1z <= EDGE_W'(signed'(vtx_rd_q[15:0]))  - EDGE_W'(signed'(v0[15:0]));
      end
      S_V3: begin
        e2x <= EDGE_W'(signed'(vtx_rd_q[47:32])) - EDGE_W'(signed'(v0[47:32]));
        e2y <= EDGE_W'(signed'(vtx_rd_q[31:16])) - EDGE_W'(signed'(v0[31:16]));
        e2z <= EDGE_W'(signed'(vtx_rd_q[15:0]))  - EDGE_W'(signed'(v0[15:0]));
      end
      S_CROSS: begin
        unique case (cnt)
          3'd1:    c0 <= prod_q[CROSS_W-1:0];
          3'd2:    c0 <= c0 - prod_q[CROSS_W-1:0];
          3'd3:    c1 <= prod_q[CROSS_W-1:0];
          3'd4:    c1 <= c1 - prod_q[CROSS_W-1:0];
          3'd5:    c2 <= prod_q[CROSS_W-1:0];
          3'd6:    c2 <= c2 - prod_q[CROSS_W-1:0];
          default: ;
        endcase
      end
      S_MAG: begin
        m0 <= c0[CROSS_W-1] ? MAG_W'(-c0) : MAG_W'(c0);
        m1 <= c1[CROSS_W-1] ? MAG_W'(-c1) : MAG_W'(c1);
        m2 <= c2[CROSS_W-1] ? MAG_W'(-c2) : MAG_W'(c2);
      end
      S_SHIFT: begin
        if (mag_or == '0) r_deg <= 1'b1;
        sm[0] <= SMAG_W'(m0 >> sh);
        sm[1] <= SMAG_W'(m1 >> sh);
        sm[2] <= SMAG_W'(m2 >> sh);
      end
      S_SQ: begin
        if (cnt == 3'd0) sum <= '0;
        else             sum <= sum + SUM_W'(prod_q);
      end
      S_NORM: if (norm_done) begin
        r_x <= c0[CROSS_W-1] ? -NRM_W'(quot[0]) : NRM_W'(quot[0]);
        r_y <= c1[CROSS_W-1] ? -NRM_W'(quot[1]) : NRM_W'(quot[1]);
        r_z <= c2[CROSS_W-1] ? -NRM_W'(quot[2]) : NRM_W'(quot[2]);
      end
      S_AWR: if (acc_x[NRM_W] || acc_y[NRM_W] || acc_z[NRM_W]) r_sat <= 1'b1;
      default: ;
    endcase

    if (out_load) begin
      normal_x   <= r_x;
      normal_y   <= r_y;
      normal_z   <= r_z;
      degenerate <= r_deg;
      saturated  <= r_sat;
    end
  end

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .mag   (sm),
    .sum   (sum),
    .done  (norm_done),
    .quot  (quot)
  );

  // ---------------- checks ----------------
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate word carries a nonzero normal");

  a_deg_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(degenerate && saturated))
    else $error("degenerate word reports saturation");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in progress");

  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    norm_done |-> state == S_NORM)
    else $error("normalizer finished outside its wait state");

  a_op_tri: assert property (@(posedge clk) disable iff (rst)
    state == S_V0 |-> op_q == OP_TRI)
    else $error("vertex fetch for a non-triangle word");

endmodule
